// ===== hw/rtl/vcjb_pkg.sv =====
// Package for the virtual cable JTAG bridge.
// Holds the item structs, command and result codes, parser phases and the banner table.
// No dependencies.
package vcjb_pkg;

  localparam logic [1:0] CMD_HOST    = 2'd0;
  localparam logic [1:0] CMD_TDO     = 2'd1;
  localparam logic [1:0] CMD_CONNECT = 2'd2;

  localparam logic [1:0] K_REPLY = 2'd0;
  localparam logic [1:0] K_PIN   = 2'd1;
  localparam logic [1:0] K_ERROR = 2'd2;

  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_H = 8'h68;

  localparam int GE_BYTES  = 6;
  localparam int SE_SKIP   = 5;
  localparam int SE_BYTES  = 9;
  localparam int SH_BYTES  = 4;
  localparam int LEN_BYTES = 4;

  localparam logic [4:0] BANNER_LAST = 5'd19;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] host_byte;
    logic       tdo_bit;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reply_byte;
    logic       tck_level;
    logic       tms_level;
    logic       tdi_level;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_GE,
    PH_SE,
    PH_SH,
    PH_LEN,
    PH_DATA,
    PH_TDO,
    PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    BK_ERROR,
    BK_BANNER,
    BK_ECHO,
    BK_START_ZERO,
    BK_START_DRIVE,
    BK_TDO_DRIVE,
    BK_TDO_REPLY_DRIVE,
    BK_TDO_REPLY_END
  } burst_e;

  typedef struct packed {
    burst_e      kind;
    logic [31:0] data;
  } burst_t;

  function automatic logic [7:0] banner_byte(logic [4:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = 8'h78;
      5'd1:    b = 8'h76;
      5'd2:    b = 8'h63;
      5'd3:    b = 8'h53;
      5'd4:    b = 8'h65;
      5'd5:    b = 8'h72;
      5'd6:    b = 8'h76;
      5'd7:    b = 8'h65;
      5'd8:    b = 8'h72;
      5'd9:    b = 8'h5f;
      5'd10:   b = 8'h76;
      5'd11:   b = 8'h31;
      5'd12:   b = 8'h2e;
      5'd13:   b = 8'h30;
      5'd14:   b = 8'h3a;
      5'd15:   b = 8'h32;
      5'd16:   b = 8'h30;
      5'd17:   b = 8'h34;
      5'd18:   b = 8'h38;
      5'd19:   b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/vcjb_emit.sv =====
// Result sequencer: holds one burst descriptor and sends its result items one per cycle unless stalled.
// Depends on vcjb_pkg.
module vcjb_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  vcjb_pkg::burst_t    desc_i,
  input  logic                tms_i,
  input  logic                tdi_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output vcjb_pkg::out_item_t out_item_o,
  output logic                free_o
);
  import vcjb_pkg::*;

  logic       valid_q;
  logic [4:0] idx_q;
  burst_t     desc_q;
  logic [4:0] last_idx;
  logic       taken;
  logic       at_last;

  always_comb begin
    unique case (desc_q.kind)
      BK_ERROR:           last_idx = 5'd0;
      BK_BANNER:          last_idx = BANNER_LAST;
      BK_ECHO:            last_idx = 5'd3;
      BK_START_ZERO:      last_idx = 5'd1;
      BK_START_DRIVE:     last_idx = 5'd2;
      BK_TDO_DRIVE:       last_idx = 5'd1;
      BK_TDO_REPLY_DRIVE: last_idx = 5'd2;
      BK_TDO_REPLY_END:   last_idx = 5'd1;
      default:            last_idx = 5'd0;
    endcase
  end

  assign taken   = valid_q && !out_stall_i;
  assign at_last = (idx_q == last_idx);
  assign free_o  = !valid_q || (taken && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 5'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 5'd0;
    end else if (taken && at_last) begin
      valid_q <= 1'b0;
    end else if (taken) begin
      idx_q <= idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

  always_comb begin
    out_item_o      = '0;
    out_item_o.last = at_last;
    unique case (desc_q.kind)
      BK_ERROR: begin
        out_item_o.kind = K_ERROR;
      end
      BK_BANNER: begin
        out_item_o.kind       = K_REPLY;
        out_item_o.reply_byte = banner_byte(idx_q);
      end
      BK_ECHO: begin
        out_item_o.kind       = K_REPLY;
        out_item_o.reply_byte = desc_q.data[{idx_q[1:0], 3'b000} +: 8];
      end
      BK_START_ZERO: begin
        out_item_o.kind      = K_PIN;
        out_item_o.tms_level = 1'b1;
        out_item_o.tdi_level = (idx_q == 5'd0);
      end
      BK_START_DRIVE, BK_TDO_REPLY_DRIVE: begin
        if (idx_q == 5'd0) begin
          if (desc_q.kind == BK_START_DRIVE) begin
            out_item_o.kind      = K_PIN;
            out_item_o.tms_level = 1'b1;
            out_item_o.tdi_level = 1'b1;
          end else begin
            out_item_o.kind       = K_REPLY;
            out_item_o.reply_byte = desc_q.data[7:0];
          end
        end else begin
          out_item_o.kind      = K_PIN;
          out_item_o.tck_level = (idx_q == 5'd2);
          out_item_o.tms_level = tms_i;
          out_item_o.tdi_level = tdi_i;
        end
      end
      BK_TDO_DRIVE: begin
        out_item_o.kind      = K_PIN;
        out_item_o.tck_level = (idx_q == 5'd1);
        out_item_o.tms_level = tms_i;
        out_item_o.tdi_level = tdi_i;
      end
      BK_TDO_REPLY_END: begin
        if (idx_q == 5'd0) begin
          out_item_o.kind       = K_REPLY;
          out_item_o.reply_byte = desc_q.data[7:0];
        end else begin
          out_item_o.kind      = K_PIN;
          out_item_o.tms_level = 1'b1;
        end
      end
      default: begin
        out_item_o.kind = K_ERROR;
      end
    endcase
  end

  assign out_valid_o = valid_q;

endmodule

// ===== hw/rtl/virtual_cable_jtag_bridge.sv =====
// Virtual cable JTAG bridge top level: command parser, vector buffer memory, result sequencer.
// Depends on vcjb_pkg and vcjb_emit.
//
//   channel | direction | payload     | handshake
//   in      | input     | in_item_t   | in_valid_i / in_stall_o
//   out     | output    | out_item_t  | out_valid_o / out_stall_i
//
// An input item causes 0 to 20 result items, sent one per cycle from the result register
// while the output is not stalled.
// The next input item is taken in the same cycle as the last result of the previous one.
// Vector bytes sit in a one-write, two-read memory; the TMS and TDI bytes of the next bit
// are read in the accept cycle and used while the pin drives go out.
// Reset clears the parser and the sequencer; the vector memory is not cleared.
// A stall on the output holds the current result and stalls the input once a burst is pending.
module virtual_cable_jtag_bridge #(
  parameter int BUFFER_BYTES = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vcjb_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vcjb_pkg::out_item_t out_item_o
);
  import vcjb_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int PW = $clog2(4 * BUFFER_BYTES + 1);

  phase_e        phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    first_q, first_d;
  logic [31:0]   bit_count_q, bit_count_d;
  logic [31:0]   echo_q, echo_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    gather_q, gather_d;
  logic [CW-1:0] total_q, total_d;

  logic          accept;
  logic          emit_free;
  logic          load;
  burst_t        desc;
  logic          rd_en;
  logic [AW-1:0] tms_addr;
  logic [AW-1:0] tdi_addr;
  logic [2:0]    rd_sel;
  logic          we;
  logic [AW-1:0] waddr;

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    tms_byte_q;
  logic [7:0]    tdi_byte_q;
  logic [2:0]    sel_q;

  logic [CW-1:0] cnt_inc;
  logic [31:0]   bc_new;
  logic [29:0]   tot_full;
  logic [PW-1:0] pos_inc;
  logic [7:0]    gather_new;
  logic          shift_done;
  logic          reply_now;
  logic [7:0]    b;

  assign accept  = in_valid_i && !in_stall_o;
  assign b       = in_item_i.host_byte;
  assign cnt_inc = cnt_q + CW'(1);
  assign bc_new  = bit_count_q | ({24'b0, b} << {cnt_q[1:0], 3'b000});
  assign tot_full = {1'b0, bc_new[31:3]} + {29'b0, |bc_new[2:0]};
  assign pos_inc = pos_q + PW'(1);
  assign gather_new = gather_q | ({7'b0, in_item_i.tdo_bit} << pos_q[2:0]);
  assign shift_done = (32'(pos_inc) >= bit_count_q);
  assign reply_now  = (pos_inc[2:0] == 3'd0) || shift_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cnt_q       <= '0;
      first_q     <= '0;
      bit_count_q <= '0;
      echo_q      <= '0;
      pos_q       <= '0;
      gather_q    <= '0;
      total_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      bit_count_q <= bit_count_d;
      echo_q      <= echo_d;
      pos_q       <= pos_d;
      gather_q    <= gather_d;
      total_q     <= total_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    bit_count_d = bit_count_q;
    echo_d      = echo_q;
    pos_d       = pos_q;
    gather_d    = gather_q;
    total_d     = total_q;
    load        = 1'b0;
    desc.kind   = BK_ERROR;
    desc.data   = '0;
    rd_en       = 1'b0;
    tms_addr    = '0;
    tdi_addr    = total_q[AW-1:0];
    rd_sel      = 3'd0;
    we          = 1'b0;
    waddr       = cnt_q[AW-1:0];
    if (accept) begin
      unique case (in_item_i.command)
        CMD_HOST: begin
          unique case (phase_q)
            PH_HEADER: begin
              if (cnt_q == '0) begin
                first_d = b;
                cnt_d   = CW'(1);
              end else begin
                cnt_d = '0;
                if (first_q == CH_G && b == CH_E) begin
                  phase_d = PH_GE;
                end else if (first_q == CH_S && b == CH_E) begin
                  phase_d = PH_SE;
                  echo_d  = '0;
                end else if (first_q == CH_S && b == CH_H) begin
                  phase_d = PH_SH;
                end else begin
                  load    = 1'b1;
                  phase_d = PH_HALT;
                end
              end
            end
            PH_GE: begin
              cnt_d = cnt_inc;
              if (cnt_inc >= CW'(GE_BYTES)) begin
                load      = 1'b1;
                desc.kind = BK_BANNER;
                phase_d   = PH_HEADER;
                cnt_d     = '0;
              end
            end
            PH_SE: begin
              if (cnt_q >= CW'(SE_SKIP)) begin
                echo_d = echo_q | ({24'b0, b} << {2'(cnt_q[1:0] - 2'd1), 3'b000});
              end
              cnt_d = cnt_inc;
              if (cnt_inc >= CW'(SE_BYTES)) begin
                load      = 1'b1;
                desc.kind = BK_ECHO;
                desc.data = echo_d;
                phase_d   = PH_HEADER;
                cnt_d     = '0;
              end
            end
            PH_SH: begin
              cnt_d = cnt_inc;
              if (cnt_inc >= CW'(SH_BYTES)) begin
                phase_d     = PH_LEN;
                cnt_d       = '0;
                bit_count_d = '0;
              end
            end
            PH_LEN: begin
              bit_count_d = bc_new;
              cnt_d       = cnt_inc;
              if (cnt_inc >= CW'(LEN_BYTES)) begin
                cnt_d = '0;
                if ({tot_full, 1'b0} > 31'(BUFFER_BYTES)) begin
                  load    = 1'b1;
                  phase_d = PH_HALT;
                end else if (tot_full == '0) begin
                  load      = 1'b1;
                  desc.kind = BK_START_ZERO;
                  pos_d     = '0;
                  gather_d  = '0;
                  phase_d   = PH_HEADER;
                end else begin
                  phase_d = PH_DATA;
                  total_d = CW'(tot_full);
                end
              end
            end
            PH_DATA: begin
              we    = 1'b1;
              cnt_d = cnt_inc;
              if (cnt_inc >= CW'(total_q << 1)) begin
                cnt_d     = '0;
                load      = 1'b1;
                desc.kind = BK_START_DRIVE;
                pos_d     = '0;
                gather_d  = '0;
                rd_en     = 1'b1;
                phase_d   = PH_TDO;
              end
            end
            PH_TDO, PH_HALT: begin
            end
            default: begin
            end
          endcase
        end
        CMD_TDO: begin
          if (phase_q == PH_TDO) begin
            pos_d     = pos_inc;
            gather_d  = reply_now ? 8'h00 : gather_new;
            desc.data = {24'b0, gather_new};
            load      = 1'b1;
            if (shift_done) begin
              desc.kind = BK_TDO_REPLY_END;
              phase_d   = PH_HEADER;
              cnt_d     = '0;
            end else begin
              desc.kind = reply_now ? BK_TDO_REPLY_DRIVE : BK_TDO_DRIVE;
              rd_en     = 1'b1;
              tms_addr  = AW'(pos_inc >> 3);
              tdi_addr  = total_q[AW-1:0] + AW'(pos_inc >> 3);
              rd_sel    = pos_inc[2:0];
            end
          end
        end
        CMD_CONNECT: begin
          phase_d  = PH_HEADER;
          cnt_d    = '0;
          first_d  = '0;
          pos_d    = '0;
          gather_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= b;
    end
    if (rd_en) begin
      tms_byte_q <= (we && waddr == tms_addr) ? b : mem[tms_addr];
      tdi_byte_q <= (we && waddr == tdi_addr) ? b : mem[tdi_addr];
      sel_q      <= rd_sel;
    end
  end

  vcjb_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .desc_i      (desc),
    .tms_i       (tms_byte_q[sel_q]),
    .tdi_i       (tdi_byte_q[sel_q]),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .free_o      (emit_free)
  );

  assign in_stall_o = !emit_free;

endmodule

// ===== hw/rtl/vcjb_checker.sv =====
// Port-level checker for the virtual cable JTAG bridge, with its bind to the top level.
// Depends on vcjb_pkg and virtual_cable_jtag_bridge.
module vcjb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input vcjb_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input vcjb_pkg::out_item_t out_item_o
);
  import vcjb_pkg::*;

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_out_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result item changed");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == K_ERROR |-> out_item_o.last)
    else $error("error result not marked last");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind virtual_cable_jtag_bridge vcjb_checker u_vcjb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
